[design/ipmac_pkg.sv]
package ipmac_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int TICK_W  = 32;
    localparam int MAXE_W  = 7;
    localparam int TTL_W   = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_ENTRIES = 2'd0,
        REG_TTL_TICKS   = 2'd1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        OUT_MATCH   = 3'd0,
        OUT_SPOOF   = 3'd1,
        OUT_REFRESH = 3'd2,
        OUT_ADDED   = 3'd3,
        OUT_FULL    = 3'd4
    } outcome_t;

    typedef struct packed {
        logic     valid;
        logic     done;
        outcome_t outcome;
    } token_t;

endpackage

[design/ipmac_cell.sv]
module ipmac_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [ipmac_pkg::IDX_W-1:0] cell_index,
    input  logic [ipmac_pkg::CNT_W-1:0] used_count,
    input  logic                        append_ok,
    input  logic [ipmac_pkg::TTL_W-1:0] ttl_ticks,
    input  logic [ipmac_pkg::IP_W-1:0]  q_ip,
    input  logic [ipmac_pkg::MAC_W-1:0] q_mac,
    input  logic [ipmac_pkg::TICK_W-1:0] q_tick,
    input  ipmac_pkg::token_t           token_in,
    output ipmac_pkg::token_t           token_out
);
    import ipmac_pkg::*;

    logic [IP_W-1:0]   ip_reg;
    logic [MAC_W-1:0]  mac_reg;
    logic [TICK_W-1:0] stamp_reg;
    token_t            token_reg;
    token_t            token_next;

    logic              active;
    logic              in_use;
    logic              hit;
    logic              add;
    logic              fresh;
    logic              wr_en;
    logic [TICK_W-1:0] age;

    always_comb begin
        active = token_in.valid && !token_in.done;
        in_use = CNT_W'(cell_index) < used_count;
        hit    = active && in_use && (ip_reg == q_ip);
        add    = active && (CNT_W'(cell_index) == used_count) && append_ok;
        age    = q_tick - stamp_reg;
        fresh  = age < {1'b0, ttl_ticks};
        wr_en  = add || (hit && !fresh);

        token_next = token_in;
        if (hit) begin
            token_next.done = 1'b1;
            if (!fresh) begin
                token_next.outcome = OUT_REFRESH;
            end else if (mac_reg != q_mac) begin
                token_next.outcome = OUT_SPOOF;
            end else begin
                token_next.outcome = OUT_MATCH;
            end
        end else if (add) begin
            token_next.done    = 1'b1;
            token_next.outcome = OUT_ADDED;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ip_reg    <= q_ip;
            mac_reg   <= q_mac;
            stamp_reg <= q_tick;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            token_reg <= '{valid: 1'b0, done: 1'b0, outcome: OUT_FULL};
        end else begin
            token_reg <= token_next;
        end
    end

    assign token_out = token_reg;

endmodule

[design/ip_mac_binding_spoof_check_core.sv]
// ip/mac binding table with time-to-live, used as a spoofing check
// input channel s_*: one sighting per transaction (ip, mac, current tick)
// result channel m_*: one transaction per sighting, spoof flag and outcome
// config channel cfg_*: index 0 max_entries, index 1 ttl_ticks, always ready
// the table is a row of TABLE_DEPTH cells, one entry each; a status token
// walks the row one cell per cycle; the first matching cell answers and
// updates itself if its entry has expired, and the cell at the fill
// point takes a new entry if the fill count is below max_entries
// one sighting at a time: the next sighting is taken in the cycle after
// the previous result reaches the output register
// reset: table emptied (fill count zero), max_entries 64, ttl_ticks 1000,
// no result pending
// receiver stall: the result waits in the output register, and a finished
// walk waits in a hold register behind it; no result is lost or repeated
module ip_mac_binding_spoof_check_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ipmac_pkg::IP_W-1:0]        s_ip_addr,
    input  logic [ipmac_pkg::MAC_W-1:0]       s_mac_addr,
    input  logic [ipmac_pkg::TICK_W-1:0]      s_tick_now,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_spoof_detected,
    output logic [2:0]                        m_outcome,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ipmac_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ipmac_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ipmac_pkg::*;

    logic [MAXE_W-1:0] max_entries_reg;
    logic [TTL_W-1:0]  ttl_ticks_reg;
    logic [CNT_W-1:0]  used_count_reg;
    logic              busy_reg;
    logic              start_reg;
    logic [IP_W-1:0]   q_ip_reg;
    logic [MAC_W-1:0]  q_mac_reg;
    logic [TICK_W-1:0] q_tick_reg;
    logic              hold_valid_reg;
    outcome_t          hold_outcome_reg;
    logic              m_valid_reg;
    outcome_t          m_outcome_reg;

    logic              s_accept;
    logic              append_ok;
    logic              out_load;
    token_t            chain [TABLE_DEPTH+1];

    assign s_ready   = !busy_reg;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_load  = hold_valid_reg && (!m_valid_reg || m_ready);
    assign append_ok = (32'(used_count_reg) < 32'(max_entries_reg)) &&
                       (32'(used_count_reg) < 32'(TABLE_DEPTH));

    assign chain[0] = '{valid: start_reg, done: 1'b0, outcome: OUT_FULL};

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        ipmac_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cell_index (IDX_W'(i)),
            .used_count (used_count_reg),
            .append_ok  (append_ok),
            .ttl_ticks  (ttl_ticks_reg),
            .q_ip       (q_ip_reg),
            .q_mac      (q_mac_reg),
            .q_tick     (q_tick_reg),
            .token_in   (chain[i]),
            .token_out  (chain[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            q_ip_reg   <= s_ip_addr;
            q_mac_reg  <= s_mac_addr;
            q_tick_reg <= s_tick_now;
        end
        if (chain[TABLE_DEPTH].valid) begin
            hold_outcome_reg <= chain[TABLE_DEPTH].outcome;
        end
        if (out_load) begin
            m_outcome_reg <= hold_outcome_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_entries_reg <= MAXE_W'(64);
            ttl_ticks_reg   <= TTL_W'(1000);
            used_count_reg  <= '0;
            busy_reg        <= 1'b0;
            start_reg       <= 1'b0;
            hold_valid_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_MAX_ENTRIES: max_entries_reg <= cfg_data[MAXE_W-1:0];
                    REG_TTL_TICKS:   ttl_ticks_reg   <= cfg_data[TTL_W-1:0];
                    default: ;
                endcase
            end

            start_reg <= s_accept;

            if (chain[TABLE_DEPTH].valid) begin
                hold_valid_reg <= 1'b1;
                if (chain[TABLE_DEPTH].outcome == OUT_ADDED) begin
                    used_count_reg <= used_count_reg + CNT_W'(1);
                end
            end else if (out_load) begin
                hold_valid_reg <= 1'b0;
            end

            if (s_accept) begin
                busy_reg <= 1'b1;
            end else if (out_load) begin
                busy_reg <= 1'b0;
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_outcome        = m_outcome_reg;
    assign m_spoof_detected = (m_outcome_reg == OUT_SPOOF);

endmodule

[tb/tb_ip_mac_binding_spoof_check_core.sv]
`timescale 1ns / 1ps

module tb_ip_mac_binding_spoof_check_core;
    import ipmac_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 11;
    localparam int WALK_CYCLES  = TABLE_DEPTH + 2;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 600;
    localparam int REPORT_MAX   = 10;

    typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    class binding_scoreboard;
        logic [IP_W-1:0]   tbl_ip    [TABLE_DEPTH];
        logic [MAC_W-1:0]  tbl_mac   [TABLE_DEPTH];
        logic [TICK_W-1:0] tbl_stamp [TABLE_DEPTH];
        int unsigned       used;
        logic [MAXE_W-1:0] max_entries;
        logic [TTL_W-1:0]  ttl;
        outcome_t          outcome_q [$];
        int                failures;

        function new();
            used = 0;
            max_entries = 7'd64;
            ttl = 31'd1000;
            failures = 0;
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= REPORT_MAX) begin
                $display("%s", msg);
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_MAX_ENTRIES) begin
                max_entries = data[MAXE_W-1:0];
            end else if (idx == REG_TTL_TICKS) begin
                ttl = data[TTL_W-1:0];
            end
        endfunction

        function void note_sighting(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac,
                                    logic [TICK_W-1:0] now);
            int unsigned       cap;
            int unsigned       i;
            bit                found;
            logic [TICK_W-1:0] age;
            outcome_t          oc;
            cap = (max_entries > TABLE_DEPTH) ? TABLE_DEPTH : max_entries;
            found = 1'b0;
            oc = OUT_FULL;
            for (i = 0; i < used && !found; i++) begin
                if (tbl_ip[i] == ip) begin
                    found = 1'b1;
                    age = now - tbl_stamp[i];
                    if (age < {1'b0, ttl}) begin
                        oc = (tbl_mac[i] != mac) ? OUT_SPOOF : OUT_MATCH;
                    end else begin
                        tbl_mac[i] = mac;
                        tbl_stamp[i] = now;
                        oc = OUT_REFRESH;
                    end
                end
            end
            if (!found) begin
                if (used < cap) begin
                    tbl_ip[used] = ip;
                    tbl_mac[used] = mac;
                    tbl_stamp[used] = now;
                    used++;
                    oc = OUT_ADDED;
                end else begin
                    oc = OUT_FULL;
                end
            end
            outcome_q.push_back(oc);
        endfunction

        function void check_result(logic spoof, logic [2:0] oc);
            outcome_t want;
            logic     want_spoof;
            if (outcome_q.size() == 0) begin
                note_failure($sformatf("unexpected result transaction: spoof=%0b outcome=%0d",
                                       spoof, oc));
            end else begin
                want = outcome_q.pop_front();
                want_spoof = (want == OUT_SPOOF);
                if (spoof !== want_spoof || oc !== want) begin
                    note_failure($sformatf(
                        "mismatch: expected spoof=%0b outcome=%s, got spoof=%0b outcome=%0d",
                        want_spoof, want.name(), spoof, oc));
                end
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [IP_W-1:0]       s_ip_addr = '0;
    logic [MAC_W-1:0]      s_mac_addr = '0;
    logic [TICK_W-1:0]     s_tick_now = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_spoof_detected;
    logic [2:0]            m_outcome;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    binding_scoreboard sb;
    int       cycle_count = 0;
    int       hold_asked = 0;
    int       hold_taken = 0;
    int       hold_left = 0;
    int       mode_left = 0;
    int       rx_count = 0;
    rx_mode_t rx_mode = RX_STEADY;

    ip_mac_binding_spoof_check_core u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_ip_addr        (s_ip_addr),
        .s_mac_addr       (s_mac_addr),
        .s_tick_now       (s_tick_now),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_spoof_detected (m_spoof_detected),
        .m_outcome        (m_outcome),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                sb.write_reg(cfg_index, cfg_data);
            end
            if (s_valid && s_ready) begin
                sb.note_sighting(s_ip_addr, s_mac_addr, s_tick_now);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_spoof_detected, m_outcome);
            end
        end
    end

    // result side stall pattern, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_asked != hold_taken) begin
            hold_taken = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            rx_count++;
            case (rx_mode)
                RX_STEADY: m_ready <= 1'b1;
                RX_COIN: m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= ($urandom_range(0, 7) == 0);
                default: m_ready <= ((rx_count % 5) < 2);
            endcase
        end
    end

    task automatic send_sighting(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac,
                                 logic [TICK_W-1:0] tick);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_ip_addr <= ip;
        s_mac_addr <= mac;
        s_tick_now <= tick;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    task automatic sender_gap(int n);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.outcome_q.size() != 0) @(posedge aclk);
    endtask

    task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
    endtask

    task automatic reconfigure(logic [MAXE_W-1:0] max_e, logic [TTL_W-1:0] ttl_val);
        drain();
        repeat (WALK_CYCLES) @(posedge aclk);
        cfg_write(REG_MAX_ENTRIES, CFG_DATA_W'(max_e));
        cfg_write(REG_TTL_TICKS, CFG_DATA_W'(ttl_val));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // mostly sightings of known ips with ticks placed around the ttl boundary
    task automatic run_phase(int count, int new_pct, bit gapless);
        int                sent;
        int                burst;
        int                k;
        int                pick;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [TICK_W-1:0] offset;
        logic [TICK_W-1:0] tick;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 10);
            repeat (burst) begin
                if (sent < count) begin
                    if ($urandom_range(0, 99) < new_pct || sb.used == 0) begin
                        ip = $urandom;
                        mac = MAC_W'({$urandom, $urandom});
                        tick = $urandom;
                    end else begin
                        k = $urandom_range(0, sb.used - 1);
                        ip = sb.tbl_ip[k];
                        pick = $urandom_range(0, 9);
                        if (pick < 6) begin
                            mac = sb.tbl_mac[k];
                        end else if (pick < 8) begin
                            mac = MAC_W'({$urandom, $urandom});
                        end else begin
                            mac = sb.tbl_mac[k] ^ (48'd1 << $urandom_range(0, MAC_W - 1));
                        end
                        pick = $urandom_range(0, 9);
                        if (pick < 5) begin
                            offset = (sb.ttl > 0) ? $urandom_range(0, sb.ttl - 1) : '0;
                        end else if (pick == 5) begin
                            offset = (sb.ttl > 0) ? {1'b0, sb.ttl} - 1 : '0;
                        end else if (pick == 6) begin
                            offset = {1'b0, sb.ttl};
                        end else if (pick < 9) begin
                            offset = {1'b0, sb.ttl} + $urandom_range(1, 5000);
                        end else begin
                            offset = $urandom;
                        end
                        tick = sb.tbl_stamp[k] + offset;
                    end
                    send_sighting(ip, mac, tick);
                    sent++;
                end
            end
            if (!gapless) begin
                if ($urandom_range(0, 49) == 0) begin
                    drain();
                end else if ($urandom_range(0, 3) != 0) begin
                    sender_gap($urandom_range(1, 12));
                end
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // capacity zero: unknown ips are dropped
        reconfigure(7'd0, 31'd0);
        send_sighting(32'h0000_0000, 48'h0000_0000_0000, 32'h0000_0000);
        send_sighting(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);

        reconfigure(7'd3, 31'd100);
        send_sighting(32'h0000_0000, 48'h0000_0000_0000, 32'h0000_0000);
        send_sighting(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFF0);
        send_sighting(32'h0000_0000, 48'h0000_0000_0000, 32'h0000_0032);
        send_sighting(32'h0000_0000, 48'h0000_0000_0001, 32'h0000_0063);
        send_sighting(32'h0000_0000, 48'h0000_0000_0001, 32'h0000_0064);
        send_sighting(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h0000_0010);
        send_sighting(32'hFFFF_FFFF, 48'h0000_0000_0000, 32'h0000_0050);
        send_sighting(32'hC0A8_0001, 48'h0123_4567_89AB, 32'h0000_00C8);
        send_sighting(32'hC0A8_0002, 48'hFEDC_BA98_7654, 32'h0000_00C8);
        send_sighting(32'hA5A5_A5A5, 48'h5A5A_5A5A_5A5A, 32'h0000_0005);
        send_sighting(32'h0000_0000, 48'h0000_0000_0001, 32'h0000_0000);

        // ttl zero: found entries always refresh
        reconfigure(7'd3, 31'd0);
        send_sighting(32'h0000_0000, 48'h0000_0000_0001, 32'h0000_0000);
        send_sighting(32'hC0A8_0001, 48'h0123_4567_89AB, 32'h0000_00C8);

        reconfigure(7'd3, 31'h7FFF_FFFF);
        send_sighting(32'h0000_0000, 48'h0000_0000_0002, 32'h7FFF_FFFE);
        send_sighting(32'h0000_0000, 48'h0000_0000_0002, 32'h7FFF_FFFF);
        send_sighting(32'h0000_0000, 48'h0000_0000_0002, 32'hFFFF_FFFE);

        reconfigure(7'd8, 31'($urandom_range(1, 300)));
        run_phase(70, 30, 1'b0);
        reconfigure(7'd20, 31'd1);
        run_phase(60, 30, 1'b0);
        reconfigure(7'd40, 31'($urandom_range(1, 5000)));
        run_phase(40, 35, 1'b0);
        hold_asked++;
        run_phase(8, 30, 1'b1);
        run_phase(50, 35, 1'b0);
        // capacity above the built depth
        reconfigure(7'd127, 31'd1000);
        run_phase(60, 45, 1'b0);
        drain();
        run_phase(70, 45, 1'b0);
        reconfigure(7'd64, 31'h7FFF_FFFF);
        run_phase(60, 20, 1'b0);
        // capacity below the fill count
        reconfigure(7'd10, 31'($urandom_range(1, 5000)));
        run_phase(80, 30, 1'b0);
        reconfigure(7'd1, 31'd0);
        run_phase(40, 20, 1'b0);
        reconfigure(7'd64, 31'd1000);
        run_phase(50, 20, 1'b0);

        drain();
        repeat (WALK_CYCLES + 8) @(posedge aclk);
        if (sb.failures == 0 && sb.outcome_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
